@@ rtl/pvr_pkg.sv @@
// ----------------------------------------------------------------------------
// pvr_pkg: shared types and constants for the portfolio volatility risk block
// Sizes of the tables and counters, fixed-point field widths, error codes,
// configuration register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pvr_pkg;

	// table and counter sizes
	localparam int MAX_ASSETS  = 64;
	localparam int MAX_RETURNS = 1024;
	localparam int ASSET_IDX_W = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
	localparam int ASSET_CNT_W = $clog2(MAX_ASSETS + 1);
	localparam int RET_CNT_W   = $clog2(MAX_RETURNS + 1);

	// field widths
	localparam int X_W     = 24;
	localparam int QTY_W   = 24;
	localparam int PRICE_W = 32;
	localparam int SCL_W   = 20;
	localparam int VOL_W   = 32;
	localparam int RISK_W  = 36;
	localparam int ERR_W   = 2;
	localparam int CFG_IDX_W = 1;

	// accumulators and products
	localparam int SUM_W  = X_W + RET_CNT_W - 1;
	localparam int SQ_W   = 2 * X_W + RET_CNT_W - 1;
	localparam int NUM_W  = RET_CNT_W + SQ_W;
	localparam int SS_W   = 2 * SUM_W;
	localparam int NN_W   = 2 * RET_CNT_W;
	localparam int PV_W   = QTY_W + PRICE_W;
	localparam int VAR_W  = 48;
	localparam int VAR_HALF = VAR_W / 2;
	localparam int TOT_W  = 64;
	localparam int WEIGHT_FRAC = 30;
	localparam int WQ_W   = WEIGHT_FRAC + 1;
	localparam int WSQ_W  = 2 * WQ_W;
	localparam int PH_W   = WQ_W + VAR_HALF;
	localparam int PROD_W = WQ_W + VAR_W;
	localparam int PVAR_W = 64;
	localparam int PVAR_SHIFT = 16;
	localparam int SCALE_FRAC = 16;
	localparam int SPROD_W = VOL_W + SCL_W;

	// shared divider
	localparam int DIV_N_W   = (NUM_W > PV_W + WEIGHT_FRAC) ? NUM_W : PV_W + WEIGHT_FRAC;
	localparam int DIV_D_W   = TOT_W;
	localparam int DIV_Q_W   = VAR_W;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	// configuration registers
	localparam logic [CFG_IDX_W-1:0] REG_VAR_SCALE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORTFALL = 1'b1;
	localparam logic [SCL_W-1:0] VAR_SCALE_RST = -20'sd107807;
	localparam logic [SCL_W-1:0] SHORTFALL_RST = 20'sd135004;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK         = 2'd0,
		ERR_ZERO_TOTAL = 2'd1,
		ERR_ASSETS     = 2'd2,
		ERR_RETURNS    = 2'd3
	} err_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic mul1;
		logic mul2;
		logic div_start;
		logic div_sel;     // 0: variance, 1: weight
		logic asset_wr;
		logic idx_clr;
		logic idx_inc;
		logic tot_clr;
		logic tot_add;
		logic pvar_clr;
		logic w_sq;
		logic w_plo;
		logic w_phi;
		logic w_sum;
		logic w_acc;
		logic sq_init;
		logic sq_step;
		logic scale;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic asset_full;
		logic div_busy;
		logic idx_end;
		logic err_nz;
		logic sq_done;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/pvr_div.sv @@
// ----------------------------------------------------------------------------
// pvr_div: radix-2 restoring divider
// One quotient bit per cycle over the whole dividend; keeps the low quotient
// bits. Shared by the per-asset variance and the per-asset weight.
// ----------------------------------------------------------------------------
module pvr_div
	import pvr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               busy,
	output logic [DIV_Q_W-1:0] quotient
);

	logic [DIV_N_W-1:0]   num_q;
	logic [DIV_D_W-1:0]   den_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_Q_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIV_D_W-1:0]   rem_sh;
	logic                 ge;

	// remainder never reaches the top bit: it stays below the divisor
	assign rem_sh = {rem_q[DIV_D_W-2:0], num_q[DIV_N_W-1]};
	assign ge     = rem_sh >= den_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_N_W-2:0], 1'b0};
			rem_q <= ge ? rem_sh - den_q : rem_sh;
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ rtl/pvr_dp.sv @@
// ----------------------------------------------------------------------------
// pvr_dp: portfolio risk datapath
// Return accumulators, asset tables, shared divider, weight and variance
// products, bit-serial square root, risk scaling and the output register.
// ----------------------------------------------------------------------------
module pvr_dp
	import pvr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic signed [X_W-1:0]    return_sample,
	input  logic signed [QTY_W-1:0]  quantity,
	input  logic [PRICE_W-1:0]       price,
	input  logic                     end_of_asset,
	input  logic                     end_of_portfolio,
	input  logic                     cfg_valid,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [SCL_W-1:0]         cfg_data,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [VOL_W-1:0]         volatility,
	output logic signed [RISK_W-1:0] value_at_risk,
	output logic signed [RISK_W-1:0] shortfall_risk,
	output logic [ERR_W-1:0]         error_code
);

	localparam logic [PVAR_W-1:0] SQ_B_INIT = PVAR_W'(1) << (PVAR_W - 2);

	// accumulators and counts
	logic [RET_CNT_W-1:0]     ret_cnt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]          sq_q;
	logic [ASSET_CNT_W-1:0]   asset_cnt_q;
	logic [1:0]               flags_q;
	logic [QTY_W-1:0]         qty_mag_q;
	logic [PRICE_W-1:0]       price_q;
	logic [SCL_W-1:0]         var_scale_q;
	logic [SCL_W-1:0]         es_scale_q;

	// per-asset products
	logic [NUM_W-1:0]         ns_q;
	logic [SS_W-1:0]          ss_q;
	logic [NN_W-1:0]          nn_q;
	logic [PV_W-1:0]          pv_q;

	// tables
	logic [PV_W-1:0]          pv_mem  [MAX_ASSETS];
	logic [VAR_W-1:0]         var_mem [MAX_ASSETS];
	logic [PV_W-1:0]          rd_pv_q;
	logic [VAR_W-1:0]         rd_var_q;
	logic [ASSET_CNT_W-1:0]   idx_q;

	// portfolio walk
	logic [TOT_W-1:0]         total_q;
	logic [WQ_W-1:0]          w2_q;
	logic [PH_W-1:0]          plo_q;
	logic [PH_W-1:0]          phi_q;
	logic [PROD_W-1:0]        prod_q;
	logic [PVAR_W-1:0]        pvar_q;
	logic [PVAR_W-1:0]        sq_x_q;
	logic [PVAR_W-1:0]        sq_r_q;
	logic [PVAR_W-1:0]        sq_b_q;
	logic [RISK_W-1:0]        sp_var_q;
	logic [RISK_W-1:0]        sp_es_q;

	// output register
	logic                     out_valid_q;
	logic [VOL_W-1:0]         vol_q;
	logic [RISK_W-1:0]        var_out_q;
	logic [RISK_W-1:0]        es_out_q;
	err_t                     err_q;

	// combinational
	logic                     eoa_in;
	logic                     ret_full;
	logic                     asset_full;
	logic [X_W-1:0]           x_mag;
	logic [2*X_W-1:0]         x_sq;
	logic [QTY_W-1:0]         qty_mag;
	logic [SUM_W-1:0]         s1_mag;
	logic [DIV_N_W-1:0]       div_dividend;
	logic [DIV_D_W-1:0]       div_divisor;
	logic                     div_busy;
	logic [DIV_Q_W-1:0]       div_quo;
	logic [WQ_W-1:0]          w;
	logic [WSQ_W-1:0]         w_sqr;
	logic [PVAR_W-1:0]        sq_rb;
	logic                     sq_ge;
	logic [VOL_W-1:0]         vol;
	logic [SCL_W-1:0]         var_mag;
	logic [SCL_W-1:0]         es_mag;
	logic [SPROD_W-1:0]       var_prod;
	logic [SPROD_W-1:0]       es_prod;
	err_t                     err_c;

	assign eoa_in     = end_of_asset | end_of_portfolio;
	assign ret_full   = ret_cnt_q == RET_CNT_W'(MAX_RETURNS);
	assign asset_full = asset_cnt_q == ASSET_CNT_W'(MAX_ASSETS);
	assign x_mag      = return_sample[X_W-1] ? X_W'(-return_sample) : X_W'(return_sample);
	assign x_sq       = (2*X_W)'(x_mag) * (2*X_W)'(x_mag);
	assign qty_mag    = quantity[QTY_W-1] ? QTY_W'(-quantity) : QTY_W'(quantity);
	assign s1_mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	// return accumulation; cleared at asset end and portfolio end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_cnt_q <= '0;
			sum_q     <= '0;
			sq_q      <= '0;
		end else if (cmd.accept) begin
			if (eoa_in && asset_full) begin
				ret_cnt_q <= '0;
				sum_q     <= '0;
				sq_q      <= '0;
			end else if (!ret_full) begin
				ret_cnt_q <= ret_cnt_q + 1'b1;
				sum_q     <= sum_q + SUM_W'(return_sample);
				sq_q      <= sq_q + SQ_W'(x_sq);
			end
		end else if (cmd.asset_wr || cmd.out_load) begin
			ret_cnt_q <= '0;
			sum_q     <= '0;
			sq_q      <= '0;
		end
	end

	// asset count and overflow flags (bit0 assets, bit1 returns)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asset_cnt_q <= '0;
			flags_q     <= '0;
		end else if (cmd.out_load) begin
			asset_cnt_q <= '0;
			flags_q     <= '0;
		end else begin
			if (cmd.asset_wr)
				asset_cnt_q <= asset_cnt_q + 1'b1;
			if (cmd.accept) begin
				if (ret_full)
					flags_q[1] <= 1'b1;
				if (eoa_in && asset_full)
					flags_q[0] <= 1'b1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_scale_q <= VAR_SCALE_RST;
			es_scale_q  <= SHORTFALL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VAR_SCALE: var_scale_q <= cfg_data;
				REG_SHORTFALL: es_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// position capture and per-asset products
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			qty_mag_q <= qty_mag;
			price_q   <= price;
		end
		if (cmd.mul1) begin
			ns_q <= NUM_W'(ret_cnt_q) * NUM_W'(sq_q);
			nn_q <= NN_W'(ret_cnt_q) * NN_W'(ret_cnt_q);
			pv_q <= PV_W'(qty_mag_q) * PV_W'(price_q);
		end
		if (cmd.mul2)
			ss_q <= SS_W'(s1_mag) * SS_W'(s1_mag);
	end

	// shared divider: variance n*S2 - S1^2 over n^2, or weight |pv|<<30 over total
	assign div_dividend = cmd.div_sel ? DIV_N_W'({rd_pv_q, {WEIGHT_FRAC{1'b0}}})
	                                  : DIV_N_W'(ns_q - NUM_W'(ss_q));
	assign div_divisor  = cmd.div_sel ? total_q : DIV_D_W'(nn_q);

	pvr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// asset tables, registered read at the walk index
	always_ff @(posedge clk) begin
		if (cmd.asset_wr) begin
			pv_mem[asset_cnt_q[ASSET_IDX_W-1:0]]  <= pv_q;
			var_mem[asset_cnt_q[ASSET_IDX_W-1:0]] <= div_quo;
		end
		rd_pv_q  <= pv_mem[idx_q[ASSET_IDX_W-1:0]];
		rd_var_q <= var_mem[idx_q[ASSET_IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (cmd.idx_clr)
			idx_q <= '0;
		else if (cmd.idx_inc)
			idx_q <= idx_q + 1'b1;
	end

	// weight squared times variance, accumulated
	assign w     = div_quo[WQ_W-1:0];
	assign w_sqr = WSQ_W'(w) * WSQ_W'(w);

	always_ff @(posedge clk) begin
		if (cmd.tot_clr)
			total_q <= '0;
		else if (cmd.tot_add)
			total_q <= total_q + TOT_W'(rd_pv_q);
		if (cmd.w_sq)
			w2_q <= w_sqr[WQ_W+WEIGHT_FRAC-1:WEIGHT_FRAC];
		if (cmd.w_plo)
			plo_q <= PH_W'(w2_q) * PH_W'(rd_var_q[VAR_HALF-1:0]);
		if (cmd.w_phi)
			phi_q <= PH_W'(w2_q) * PH_W'(rd_var_q[VAR_W-1:VAR_HALF]);
		if (cmd.w_sum)
			prod_q <= (PROD_W'(phi_q) << VAR_HALF) + PROD_W'(plo_q);
		if (cmd.pvar_clr)
			pvar_q <= '0;
		else if (cmd.w_acc)
			pvar_q <= pvar_q + PVAR_W'(prod_q[PROD_W-1:WEIGHT_FRAC]);
	end

	// bit-serial square root, two radicand bits per step
	assign sq_rb = sq_r_q + sq_b_q;
	assign sq_ge = sq_x_q >= sq_rb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_b_q <= '0;
		end else if (cmd.sq_init) begin
			sq_b_q <= SQ_B_INIT;
		end else if (cmd.sq_step) begin
			sq_b_q <= sq_b_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_init) begin
			sq_x_q <= pvar_q << PVAR_SHIFT;
			sq_r_q <= '0;
		end else if (cmd.sq_step) begin
			if (sq_ge) begin
				sq_x_q <= sq_x_q - sq_rb;
				sq_r_q <= (sq_r_q >> 1) + sq_b_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
		end
	end

	// risk scaling on magnitudes, sign applied at output load
	assign vol      = sq_r_q[VOL_W-1:0];
	assign var_mag  = var_scale_q[SCL_W-1] ? SCL_W'(-var_scale_q) : var_scale_q;
	assign es_mag   = es_scale_q[SCL_W-1] ? SCL_W'(-es_scale_q) : es_scale_q;
	assign var_prod = SPROD_W'(vol) * SPROD_W'(var_mag);
	assign es_prod  = SPROD_W'(vol) * SPROD_W'(es_mag);

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			sp_var_q <= var_prod[SPROD_W-1:SCALE_FRAC];
			sp_es_q  <= es_prod[SPROD_W-1:SCALE_FRAC];
		end
	end

	// error precedence: returns, assets, zero total
	always_comb begin
		if (flags_q[1])
			err_c = ERR_RETURNS;
		else if (flags_q[0])
			err_c = ERR_ASSETS;
		else if (total_q == '0)
			err_c = ERR_ZERO_TOTAL;
		else
			err_c = ERR_OK;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			err_q <= err_c;
			if (err_c != ERR_OK) begin
				vol_q     <= '0;
				var_out_q <= '0;
				es_out_q  <= '0;
			end else begin
				vol_q     <= vol;
				var_out_q <= var_scale_q[SCL_W-1] ? RISK_W'(-sp_var_q) : sp_var_q;
				es_out_q  <= es_scale_q[SCL_W-1] ? RISK_W'(-sp_es_q) : sp_es_q;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign volatility     = vol_q;
	assign value_at_risk  = var_out_q;
	assign shortfall_risk = es_out_q;
	assign error_code     = err_q;

	// status
	assign sts = '{
		asset_full: asset_full,
		div_busy:   div_busy,
		idx_end:    idx_q == asset_cnt_q,
		err_nz:     err_c != ERR_OK,
		sq_done:    sq_b_q == '0,
		out_free:   !out_valid_q || out_ready
	};

endmodule

@@ rtl/pvr_ctrl.sv @@
// ----------------------------------------------------------------------------
// pvr_ctrl: portfolio risk sequencer
// Takes input items, runs the asset-end variance step and the portfolio-end
// walk (total, weights, square root, scaling) and hands off the result.
// ----------------------------------------------------------------------------
module pvr_ctrl
	import pvr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic end_of_asset,
	input  logic end_of_portfolio,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [19:0] {
		S_IDLE    = 20'h00001,
		S_A_MUL1  = 20'h00002,
		S_A_MUL2  = 20'h00004,
		S_A_DIV   = 20'h00008,
		S_A_WAIT  = 20'h00010,
		S_T_RD    = 20'h00020,
		S_T_ACC   = 20'h00040,
		S_W_RD    = 20'h00080,
		S_W_DIV   = 20'h00100,
		S_W_WAIT  = 20'h00200,
		S_W_SQ    = 20'h00400,
		S_W_PLO   = 20'h00800,
		S_W_PHI   = 20'h01000,
		S_W_SUM   = 20'h02000,
		S_W_ACC   = 20'h04000,
		S_SQ_INIT = 20'h08000,
		S_SQ_RUN  = 20'h10000,
		S_SCALE   = 20'h20000,
		S_OUT     = 20'h40000,
		S_SPARE   = 20'h80000
	} state_t;

	state_t state_q, state_d;
	logic   eop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eop_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept)
				eop_q <= end_of_portfolio;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if ((end_of_asset || end_of_portfolio) && !sts.asset_full) begin
						state_d = S_A_MUL1;
					end else if (end_of_portfolio) begin
						cmd.idx_clr = 1'b1;
						cmd.tot_clr = 1'b1;
						state_d     = S_T_RD;
					end
				end
			end
			S_A_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_A_MUL2;
			end
			S_A_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_A_DIV;
			end
			S_A_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = S_A_WAIT;
			end
			S_A_WAIT: begin
				if (!sts.div_busy) begin
					cmd.asset_wr = 1'b1;
					if (eop_q) begin
						cmd.idx_clr = 1'b1;
						cmd.tot_clr = 1'b1;
						state_d     = S_T_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			// sum of absolute position values
			S_T_RD: begin
				if (sts.idx_end) begin
					if (sts.err_nz) begin
						state_d = S_OUT;
					end else begin
						cmd.idx_clr  = 1'b1;
						cmd.pvar_clr = 1'b1;
						state_d      = S_W_RD;
					end
				end else begin
					state_d = S_T_ACC;
				end
			end
			S_T_ACC: begin
				cmd.tot_add = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_T_RD;
			end
			// weighted variance walk
			S_W_RD: begin
				state_d = sts.idx_end ? S_SQ_INIT : S_W_DIV;
			end
			S_W_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_d       = S_W_WAIT;
			end
			S_W_WAIT: begin
				if (!sts.div_busy)
					state_d = S_W_SQ;
			end
			S_W_SQ: begin
				cmd.w_sq = 1'b1;
				state_d  = S_W_PLO;
			end
			S_W_PLO: begin
				cmd.w_plo = 1'b1;
				state_d   = S_W_PHI;
			end
			S_W_PHI: begin
				cmd.w_phi = 1'b1;
				state_d   = S_W_SUM;
			end
			S_W_SUM: begin
				cmd.w_sum = 1'b1;
				state_d   = S_W_ACC;
			end
			S_W_ACC: begin
				cmd.w_acc   = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_W_RD;
			end
			// square root and scaling
			S_SQ_INIT: begin
				cmd.sq_init = 1'b1;
				state_d     = S_SQ_RUN;
			end
			S_SQ_RUN: begin
				if (sts.sq_done)
					state_d = S_SCALE;
				else
					cmd.sq_step = 1'b1;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/portfolio_volatility_risk.sv @@
// ----------------------------------------------------------------------------
// portfolio_volatility_risk: diagonal portfolio volatility, VaR and ES
// Accumulates returns per asset, stores position value and variance, and on
// the portfolio end emits volatility with scaled VaR and expected shortfall.
// ----------------------------------------------------------------------------
// An ordinary return item is taken while the block stays idle and ready for
// the next. An item that ends an asset, while the asset table has room, keeps
// the block busy while the 86-step serial divider forms the variance. An item
// that ends the portfolio then sums the N stored position values, runs the
// weight division and weighted variance for each asset, closes that walk and
// runs the bit-serial square root (setup, 32 steps, done check), scaling and
// output load; an error found after the sum goes straight to output load.
// Results sit in an output register, so the next item is taken while a result
// waits; the next result load waits until that register is free. The asset
// tables are not cleared after reset; entries are written before they are read.
module portfolio_volatility_risk
	import pvr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [X_W-1:0]    return_sample,
	input  logic signed [QTY_W-1:0]  quantity,
	input  logic [PRICE_W-1:0]       price,
	input  logic                     end_of_asset,
	input  logic                     end_of_portfolio,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [SCL_W-1:0]         cfg_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [VOL_W-1:0]         volatility,
	output logic signed [RISK_W-1:0] value_at_risk,
	output logic signed [RISK_W-1:0] shortfall_risk,
	output logic [ERR_W-1:0]         error_code
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	pvr_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.end_of_asset     (end_of_asset),
		.end_of_portfolio (end_of_portfolio),
		.in_ready         (in_ready),
		.sts              (sts),
		.cmd              (cmd)
	);

	pvr_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.return_sample    (return_sample),
		.quantity         (quantity),
		.price            (price),
		.end_of_asset     (end_of_asset),
		.end_of_portfolio (end_of_portfolio),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.volatility       (volatility),
		.value_at_risk    (value_at_risk),
		.shortfall_risk   (shortfall_risk),
		.error_code       (error_code)
	);

endmodule

@@ rtl/pvr_checker.sv @@
// ----------------------------------------------------------------------------
// pvr_checker: port-level checks for the portfolio risk block
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module pvr_checker
	import pvr_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     end_of_portfolio,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [VOL_W-1:0]         volatility,
	input logic signed [RISK_W-1:0] value_at_risk,
	input logic signed [RISK_W-1:0] shortfall_risk,
	input logic [ERR_W-1:0]         error_code
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(volatility) &&
		$stable(value_at_risk) && $stable(shortfall_risk) && $stable(error_code))
		else $error("result changed while stalled");

	// an error result carries no risk figures
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_OK |->
		volatility == '0 && value_at_risk == '0 && shortfall_risk == '0)
		else $error("nonzero figures with error code");

	// a portfolio end item starts the result computation
	a_eop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_portfolio |=> !in_ready)
		else $error("input taken right after portfolio end");

	// results are loaded only while the block is busy
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

bind portfolio_volatility_risk pvr_checker u_pvr_checker (.*);
